/* rtl/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and defaults for the hashed bucket deque.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

  localparam int unsigned NumBucketsDefault  = 4;
  localparam int unsigned BucketDepthDefault = 16;
  localparam int unsigned DataWidthDefault   = 32;

  // Widths of the fixed transaction fields
  localparam int unsigned OpWidth     = 2;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_L = 2'd0,
    OP_PUSH_R = 2'd1,
    OP_POP_L  = 2'd2,
    OP_POP_R  = 2'd3
  } hbd_op_e;

  typedef enum logic [StatusWidth-1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } hbd_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } hbd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;  // latch the incoming transaction
    logic exec;  // look up bucket, update store and pointers
    logic load;  // move the result into the output register
  } hbd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } hbd_sts_t;

endpackage

`default_nettype wire

/* rtl/hbd_ram.sv */
// ----------------------------------------------------------------------------
// hbd_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/hbd_ctrl.sv */
// ----------------------------------------------------------------------------
// hbd_ctrl
// Sequencer: accept, execute, hand result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire hbd_pkg::hbd_sts_t sts_i,
  output hbd_pkg::hbd_cmd_t      cmd_o
);

  hbd_pkg::hbd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      hbd_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = hbd_pkg::S_EXEC;
        end
      end
      hbd_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = hbd_pkg::S_DONE;
      end
      hbd_pkg::S_DONE: begin
        // wait for room in the output register
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = hbd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hbd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/hbd_dp.sv */
// ----------------------------------------------------------------------------
// hbd_dp
// Datapath: bucket pointers, entry store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_dp #(
  parameter int unsigned NUM_BUCKETS  = hbd_pkg::NumBucketsDefault,
  parameter int unsigned BUCKET_DEPTH = hbd_pkg::BucketDepthDefault,
  parameter int unsigned DATA_WIDTH   = hbd_pkg::DataWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hbd_pkg::hbd_cmd_t             cmd_i,
  output hbd_pkg::hbd_sts_t                  sts_o,
  input  wire logic [hbd_pkg::OpWidth-1:0]   op_i,
  input  wire logic [hbd_pkg::ValueWidth-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hbd_pkg::ValueWidth-1:0]     out_value_o,
  output logic [hbd_pkg::StatusWidth-1:0]    out_status_o
);

  localparam int unsigned BW = $clog2(NUM_BUCKETS);
  localparam int unsigned SW = $clog2(BUCKET_DEPTH);
  localparam int unsigned PW = SW + 1;
  localparam int unsigned CW = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned MD = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned AW = $clog2(MD);

  // Latched transaction
  hbd_pkg::hbd_op_e      op_q;
  logic [DATA_WIDTH-1:0] val_q;

  // Per-bucket pointers and end indexes
  logic [SW-1:0] head_q  [NUM_BUCKETS];
  logic [CW-1:0] count_q [NUM_BUCKETS];
  logic [BW-1:0] lidx_q, ridx_q;

  // Pending result
  hbd_pkg::hbd_status_e status_q;
  logic                 popok_q;

  // Output register
  logic                                out_valid_q;
  logic [hbd_pkg::ValueWidth-1:0]      out_value_q;
  logic [hbd_pkg::StatusWidth-1:0]     out_status_q;

  logic                  is_push, is_pop;
  logic [BW-1:0]         bkt;
  logic [SW-1:0]         h, head_dec, head_inc, tail, slot;
  logic [CW-1:0]         c;
  logic [PW-1:0]         tail_sum;
  logic                  full, empty, ok;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= hbd_pkg::hbd_op_e'(op_i);
      val_q <= DATA_WIDTH'(value_i);
    end
  end

  assign is_push = (op_q == hbd_pkg::OP_PUSH_L) || (op_q == hbd_pkg::OP_PUSH_R);
  assign is_pop  = !is_push;

  always_comb begin
    case (op_q)
      hbd_pkg::OP_PUSH_L: bkt = lidx_q;
      hbd_pkg::OP_PUSH_R: bkt = ridx_q;
      hbd_pkg::OP_POP_L:  bkt = lidx_q + BW'(1);
      hbd_pkg::OP_POP_R:  bkt = ridx_q - BW'(1);
      default:            bkt = lidx_q;
    endcase
  end

  assign h     = head_q[bkt];
  assign c     = count_q[bkt];
  assign full  = (c == CW'(BUCKET_DEPTH));
  assign empty = (c == '0);
  assign ok    = is_push ? !full : !empty;

  assign head_dec = (h == '0) ? SW'(BUCKET_DEPTH - 1) : h - SW'(1);
  assign head_inc = (h == SW'(BUCKET_DEPTH - 1)) ? '0 : h + SW'(1);

  // tail slot: head + count for a left push, one less for a left pop
  assign tail_sum = PW'(h) + PW'(c) - PW'(op_q == hbd_pkg::OP_POP_L);
  assign tail     = (tail_sum >= PW'(BUCKET_DEPTH)) ? SW'(tail_sum - PW'(BUCKET_DEPTH))
                                                     : SW'(tail_sum);

  always_comb begin
    case (op_q)
      hbd_pkg::OP_PUSH_L: slot = tail;
      hbd_pkg::OP_PUSH_R: slot = head_dec;
      hbd_pkg::OP_POP_L:  slot = tail;
      hbd_pkg::OP_POP_R:  slot = h;
      default:            slot = h;
    endcase
  end

  assign ram_addr = AW'(bkt) * AW'(BUCKET_DEPTH) + AW'(slot);
  assign ram_we   = cmd_i.exec && ok && is_push;
  assign ram_re   = cmd_i.exec && ok && is_pop;

  hbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      lidx_q <= '0;
      ridx_q <= BW'(1);
    end else if (cmd_i.exec && ok) begin
      case (op_q)
        hbd_pkg::OP_PUSH_L: begin
          count_q[bkt] <= c + CW'(1);
          lidx_q       <= bkt - BW'(1);
        end
        hbd_pkg::OP_PUSH_R: begin
          head_q[bkt]  <= head_dec;
          count_q[bkt] <= c + CW'(1);
          ridx_q       <= bkt + BW'(1);
        end
        hbd_pkg::OP_POP_L: begin
          count_q[bkt] <= c - CW'(1);
          lidx_q       <= bkt;
        end
        hbd_pkg::OP_POP_R: begin
          head_q[bkt]  <= head_inc;
          count_q[bkt] <= c - CW'(1);
          ridx_q       <= bkt;
        end
        default: begin
          lidx_q <= lidx_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= ok ? hbd_pkg::STS_DONE
                     : (is_push ? hbd_pkg::STS_FULL : hbd_pkg::STS_EMPTY);
      popok_q  <= ok && is_pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_value_q  <= popok_q ? hbd_pkg::ValueWidth'(ram_rdata) : '0;
      out_status_q <= status_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_status_o   = out_status_q;

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read in one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> (c <= CW'(BUCKET_DEPTH)))
    else $error("bucket count beyond depth");

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an undelivered one");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_pop && empty) |=> (status_q == hbd_pkg::STS_EMPTY) && !popok_q)
    else $error("empty pop not flagged");
`endif

endmodule

`default_nettype wire

/* rtl/hashed_bucket_deque.sv */
// From input acceptance to the result on the master side the sequencer steps
//   through accept, bucket lookup with store access, and result load, which
//   waits for room in the output register. It handles one transaction at a
//   time, and the single store port is read or written in the lookup cycle.
// Reset: rst_ni asynchronous, active low; all buckets empty, left index 0,
//   right index 1. Entry data is not cleared.
// ----------------------------------------------------------------------------
// hashed_bucket_deque
// Double-ended queue spread over a power-of-two number of bounded buckets.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_bucket_deque #(
  parameter int unsigned NUM_BUCKETS  = hbd_pkg::NumBucketsDefault,
  parameter int unsigned BUCKET_DEPTH = hbd_pkg::BucketDepthDefault,
  parameter int unsigned DATA_WIDTH   = hbd_pkg::DataWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side: operation in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [31:0] push_value
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] opcode
  // Master side: result out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [31:0] pop_value
  output logic [1:0]       m_axis_tuser_o   // [1:0] status
);

  // Controller and datapath talk only through these two bundles
  hbd_pkg::hbd_cmd_t cmd;
  hbd_pkg::hbd_sts_t sts;

  hbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // The datapath holds the output register, so a finished result waits there
  // while the controller already takes the next transaction.
  hbd_dp #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser_i),
    .value_i      (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

/* sim/hbd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hbd_checker
// Watches both stream channels of the bucket deque, keeps its own copy of the
// buckets and indexes, and checks every result transaction in order.
// ----------------------------------------------------------------------------

module hbd_checker
  import hbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [ValueWidth-1:0] s_data_i,
  input  logic [OpWidth-1:0]    s_user_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [ValueWidth-1:0] m_data_i,
  input  logic [StatusWidth-1:0] m_user_i,
  output int unsigned           fail_count_o,
  output int unsigned           outstanding_o
);

  localparam int unsigned NumBuckets  = NumBucketsDefault;
  localparam int unsigned BucketDepth = BucketDepthDefault;
  localparam int unsigned IdxW        = $clog2(NumBuckets);
  localparam int unsigned SlotW       = $clog2(BucketDepth);

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    hbd_status_e           status;
  } deque_reply_t;

  // Shadow of the deque: entry data, head slot and fill level per bucket
  logic [ValueWidth-1:0] entries    [NumBuckets][BucketDepth];
  logic [SlotW-1:0]      head_slot  [NumBuckets];
  logic [SlotW:0]        fill_level [NumBuckets];
  logic [IdxW-1:0]       left_bkt;
  logic [IdxW-1:0]       right_bkt;

  deque_reply_t replies_due [$];
  deque_reply_t want;
  int unsigned  mismatches;

  // Applies one operation to the shadow deque and returns its reply
  function automatic deque_reply_t deque_apply(hbd_op_e op, logic [ValueWidth-1:0] value);
    deque_reply_t    reply;
    logic [IdxW-1:0] b;
    logic [SlotW-1:0] slot;
    reply.value  = '0;
    reply.status = STS_DONE;
    case (op)
      OP_PUSH_L: begin
        b = left_bkt;
        if (fill_level[b] == BucketDepth) begin
          reply.status = STS_FULL;
        end else begin
          slot = head_slot[b] + fill_level[b][SlotW-1:0];
          entries[b][slot] = value;
          fill_level[b]++;
          left_bkt = b - 1'b1;
        end
      end
      OP_PUSH_R: begin
        b = right_bkt;
        if (fill_level[b] == BucketDepth) begin
          reply.status = STS_FULL;
        end else begin
          head_slot[b] = head_slot[b] - 1'b1;
          entries[b][head_slot[b]] = value;
          fill_level[b]++;
          right_bkt = b + 1'b1;
        end
      end
      OP_POP_L: begin
        b = left_bkt + 1'b1;
        if (fill_level[b] == 0) begin
          reply.status = STS_EMPTY;
        end else begin
          slot = head_slot[b] + fill_level[b][SlotW-1:0] - 1'b1;
          reply.value = entries[b][slot];
          fill_level[b]--;
          left_bkt = b;
        end
      end
      default: begin
        b = right_bkt - 1'b1;
        if (fill_level[b] == 0) begin
          reply.status = STS_EMPTY;
        end else begin
          reply.value = entries[b][head_slot[b]];
          head_slot[b] = head_slot[b] + 1'b1;
          fill_level[b]--;
          right_bkt = b;
        end
      end
    endcase
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBuckets; i++) begin
        head_slot[i]  = '0;
        fill_level[i] = '0;
      end
      left_bkt  = '0;
      right_bkt = IdxW'(1);
      replies_due.delete();
      mismatches = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // results first: with a registered datapath a result never belongs
      // to the operation accepted at the same edge
      if (m_valid_i && m_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing outstanding, pop_value %h status %0d",
                   $time, m_data_i, m_user_i);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (m_data_i !== want.value) begin
            $display("%0t: pop_value mismatch, expected %h, actual %h",
                     $time, want.value, m_data_i);
            mismatches++;
          end
          if (m_user_i !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, m_user_i);
            mismatches++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        replies_due.push_back(deque_apply(hbd_op_e'(s_user_i), s_data_i));
      end
      fail_count_o  <= mismatches;
      outstanding_o <= replies_due.size();
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives operations into the bucket deque with random gaps and back-pressure;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
  import hbd_pkg::*;

  localparam int unsigned TotalOps   = 1050;
  localparam int unsigned HoldAfter  = 300;  // results seen before the long hold-off
  localparam int unsigned HoldCycles = 400;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [ValueWidth-1:0]  s_axis_tdata;
  logic [OpWidth-1:0]     s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [ValueWidth-1:0]  m_axis_tdata;
  logic [StatusWidth-1:0] m_axis_tuser;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned ops_sent;
  bit          calm_tx;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  hashed_bucket_deque DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  hbd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Mostly back-to-back, some short gaps, the odd long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Random payload with the extremes turning up now and then
  function automatic logic [ValueWidth-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_op(input hbd_op_e op, input logic [ValueWidth-1:0] value);
    int unsigned gap;
    gap = calm_tx ? 0 : idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
  end

  // Sender: directed opening, then phases biased towards filling or draining
  initial begin
    int unsigned phase_len;
    int unsigned push_pct;
    int unsigned phase_no;
    hbd_op_e     op;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_PUSH_L;
    ops_sent      = 0;
    calm_tx       = 1'b0;
    phase_no      = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // pops on an empty deque, then pushes from both ends with extreme data
    send_op(OP_POP_L, '1);
    send_op(OP_POP_R, '0);
    send_op(OP_PUSH_L, '0);
    send_op(OP_PUSH_L, '1);
    send_op(OP_PUSH_R, '1);
    send_op(OP_PUSH_R, '0);
    send_op(OP_PUSH_L, 32'h8000_0000);
    send_op(OP_PUSH_R, 32'h0000_0001);
    send_op(OP_PUSH_R, 32'hA5A5_5A5A);
    // drain from both ends, wrapping both indexes, and past empty
    send_op(OP_POP_L, '0);
    send_op(OP_POP_R, '1);
    send_op(OP_POP_L, '0);
    send_op(OP_POP_R, '1);
    send_op(OP_POP_L, '0);
    send_op(OP_POP_R, '1);
    send_op(OP_POP_L, '0);
    send_op(OP_POP_R, '0);
    send_op(OP_POP_L, '0);
    send_op(OP_POP_R, '0);
    send_op(OP_PUSH_L, 32'h5A5A_A5A5);
    send_op(OP_POP_R, '0);

    // Push-heavy phases overrun the bucket capacity and hit the full case;
    // pop-heavy ones drain to empty again.
    while (ops_sent < TotalOps) begin
      phase_len = $urandom_range(40, 180);
      if (phase_len > TotalOps - ops_sent) phase_len = TotalOps - ops_sent;
      case (phase_no == 0 ? 0 : $urandom_range(0, 3))
        0:       push_pct = 90;
        1:       push_pct = 10;
        2:       push_pct = 50;
        default: push_pct = 70;
      endcase
      calm_tx = ($urandom_range(0, 3) == 0);
      phase_no++;
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_R : OP_PUSH_L;
        else
          op = $urandom_range(0, 1) ? OP_POP_R : OP_POP_L;
        send_op(op, pick_value());
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the pipeline empty out, then keep watching for stray results
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[hashed_bucket_deque] OK");
    end else begin
      $display("[hashed_bucket_deque] ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off so the
  // block backs up and stops taking transactions
  initial begin
    int unsigned stall_cnt;
    int unsigned gap;
    int unsigned tick;
    bit          hold_done;
    bit          calm_rx;
    m_axis_tready = 1'b0;
    stall_cnt     = 0;
    tick          = 0;
    hold_done     = 1'b0;
    calm_rx       = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 100 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        stall_cnt = HoldCycles;
      end
      if (stall_cnt != 0) begin
        m_axis_tready <= 1'b0;
        stall_cnt--;
      end else begin
        gap = calm_rx ? 0 : idle_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          stall_cnt = gap - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[hashed_bucket_deque] ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/hbd_pkg.sv
rtl/hbd_ram.sv
rtl/hbd_ctrl.sv
rtl/hbd_dp.sv
rtl/hashed_bucket_deque.sv
sim/hbd_checker.sv
sim/testbench.sv
